// ----- sv/wsmv_pkg.sv -----
// ----------------------------------------------------------------------------
// wsmv_pkg
// Shared types and constants for the weighted scalar mean/variance block.
// ----------------------------------------------------------------------------
package wsmv_pkg;

    // field widths
    localparam int VALUE_W      = 16;
    localparam int WEIGHT_W     = 16;
    localparam int MEAN_W       = 16;
    localparam int VAR_W        = 40;
    localparam int USED_W       = 11;
    localparam int FRAC_BITS    = 8;

    // default store depth
    localparam int MAX_SAMPLES_DEF = 1024;

    // shared multiplier operand widths
    localparam int MUL_A_W      = 2 * VALUE_W;
    localparam int MUL_B_W      = WEIGHT_W;
    localparam int MUL_P_W      = MUL_A_W + MUL_B_W;

    // divider: quotient shift register and step counter
    localparam int QUO_W        = VAR_W;
    localparam int STEP_W       = $clog2(QUO_W + 1);
    localparam int MEAN_STEPS   = MEAN_W;
    localparam int VAR_STEPS    = VAR_W;

    // stream widths
    localparam int S_TDATA_W    = VALUE_W + WEIGHT_W;
    localparam int M_PAYLOAD_W  = MEAN_W + VAR_W + USED_W;
    localparam int M_TDATA_W    = ((M_PAYLOAD_W + 7) / 8) * 8;
    localparam int M_TUSER_W    = 2;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LMUL,
        ST_LACC,
        ST_MSTART,
        ST_MWAIT,
        ST_PRD,
        ST_PSQ,
        ST_PWM,
        ST_PAC,
        ST_VSTART,
        ST_VWAIT,
        ST_DONE
    } state_t;

    // divider handshake
    typedef struct packed {
        logic start;
        logic [STEP_W-1:0] steps;
    } div_ctrl_t;

endpackage

// ----- sv/wsmv_div.sv -----
// ----------------------------------------------------------------------------
// wsmv_div
// Restoring divider, one quotient bit per cycle. The caller supplies the
// upper part of the dividend as the starting remainder (already below the
// divisor) and the lower bits, MSB first, to shift in.
// ----------------------------------------------------------------------------
module wsmv_div #(
    parameter int DEN_W = 27
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  wsmv_pkg::div_ctrl_t           ctrl,
    input  logic [DEN_W-1:0]              rem_init,
    input  logic [wsmv_pkg::QUO_W-1:0]    low_bits,
    input  logic [DEN_W-1:0]              den,
    output logic                          done,
    output logic [wsmv_pkg::QUO_W-1:0]    quotient
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [wsmv_pkg::STEP_W-1:0]   cnt_reg, cnt_next;
    logic [DEN_W-1:0]              rem_reg, rem_next;
    logic [DEN_W-1:0]              den_reg, den_next;
    logic [wsmv_pkg::QUO_W-1:0]    low_reg, low_next;
    logic [wsmv_pkg::QUO_W-1:0]    quo_reg, quo_next;
    logic [DEN_W:0]                rem_sh;
    logic [DEN_W:0]                diff;
    logic                          ge;

    // one compare-subtract step
    always_comb begin
        rem_sh = {rem_reg, low_reg[wsmv_pkg::QUO_W-1]};
        diff   = rem_sh - {1'b0, den_reg};
        ge     = (rem_sh >= {1'b0, den_reg});
    end

    // step control
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        if (ctrl.start) begin
            busy_next = 1'b1;
            cnt_next  = ctrl.steps;
            rem_next  = rem_init;
            den_next  = den;
            low_next  = low_bits;
            quo_next  = '0;
        end else if (busy_reg) begin
            rem_next = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            low_next = {low_reg[wsmv_pkg::QUO_W-2:0], 1'b0};
            quo_next = {quo_reg[wsmv_pkg::QUO_W-2:0], ge};
            cnt_next = cnt_reg - wsmv_pkg::STEP_W'(1);
            if (cnt_reg == wsmv_pkg::STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        den_reg <= den_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- sv/weighted_scalar_mean_variance.sv -----
// ----------------------------------------------------------------------------
// weighted_scalar_mean_variance
// Stores weighted samples, then on the last one forms the weighted mean
// (rounded half up) and the biased weighted variance with 8 fraction bits.
// ----------------------------------------------------------------------------
// Input: a stored sample that is not last is accepted, multiplied on the one
//   shared multiplier and accumulated before the input is ready again; a
//   dropped sample that is not last leaves the input ready.
// After the last sample: 16-step mean division; a second pass reads, squares,
//   weights and accumulates each stored sample; 40-step variance division.
// Reset clears the sequencer, sample count, sums and output valid; the sample
//   stores are not cleared (only entries written in the current set are read).
// ----------------------------------------------------------------------------
module weighted_scalar_mean_variance #(
    parameter int MAX_SAMPLES = wsmv_pkg::MAX_SAMPLES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // s_tdata: sample_value [15:0], sample_weight [31:16]
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [wsmv_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tlast,
    // m_tdata: mean_value [15:0], variance_q8 [55:16], samples_used [66:56]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [wsmv_pkg::M_TDATA_W-1:0]    m_tdata,
    // m_tuser: zero_weight_error [0], capacity_overflow [1]
    output logic [wsmv_pkg::M_TUSER_W-1:0]    m_tuser
);

    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int ADDR_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int WT_W   = wsmv_pkg::WEIGHT_W + CNT_W;
    localparam int SUM_W  = wsmv_pkg::VALUE_W + wsmv_pkg::WEIGHT_W + CNT_W;
    localparam int DS_W   = wsmv_pkg::MUL_P_W + CNT_W;
    localparam int DEN_W  = WT_W + 1;
    localparam int N1_W   = SUM_W + 2;

    // sample stores
    logic [wsmv_pkg::VALUE_W-1:0]  value_mem  [MAX_SAMPLES];
    logic [wsmv_pkg::WEIGHT_W-1:0] weight_mem [MAX_SAMPLES];

    wsmv_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic [CNT_W-1:0]               idx_reg, idx_next;
    logic [SUM_W-1:0]               sum_reg, sum_next;
    logic [WT_W-1:0]                wt_reg, wt_next;
    logic                           drop_reg, drop_next;
    logic [DS_W-1:0]                dsum_reg, dsum_next;
    logic [wsmv_pkg::VALUE_W-1:0]   x_reg, x_next;
    logic [wsmv_pkg::WEIGHT_W-1:0]  w_reg, w_next;
    logic                           last_reg, last_next;
    logic [wsmv_pkg::MEAN_W-1:0]    mean_reg, mean_next;
    logic [wsmv_pkg::VAR_W-1:0]     var_reg, var_next;
    logic                           zero_reg, zero_next;
    logic [wsmv_pkg::MUL_P_W-1:0]   mul_reg;
    logic [wsmv_pkg::VALUE_W-1:0]   rd_x_reg;
    logic [wsmv_pkg::WEIGHT_W-1:0]  rd_w_reg;

    // output register
    logic                           m_valid_reg, m_valid_next;
    logic [wsmv_pkg::MEAN_W-1:0]    o_mean_reg, o_mean_next;
    logic [wsmv_pkg::VAR_W-1:0]     o_var_reg, o_var_next;
    logic                           o_zero_reg, o_zero_next;
    logic                           o_drop_reg, o_drop_next;
    logic [wsmv_pkg::USED_W-1:0]    o_used_reg, o_used_next;

    logic                           s_accept;
    logic                           full;
    logic                           mem_we;
    logic                           mem_re;
    logic [wsmv_pkg::VALUE_W-1:0]   in_value;
    logic [wsmv_pkg::WEIGHT_W-1:0]  in_weight;
    logic [wsmv_pkg::MUL_A_W-1:0]   mul_a;
    logic [wsmv_pkg::MUL_B_W-1:0]   mul_b;
    logic                           mul_en;
    logic [wsmv_pkg::VALUE_W-1:0]   mag;
    logic [N1_W-1:0]                n1;

    wsmv_pkg::div_ctrl_t            div_ctrl;
    logic [DEN_W-1:0]               div_rem_init;
    logic [wsmv_pkg::QUO_W-1:0]     div_low;
    logic [DEN_W-1:0]               div_den;
    logic                           div_done;
    logic [wsmv_pkg::QUO_W-1:0]     div_quo;

    assign in_value  = s_tdata[wsmv_pkg::VALUE_W-1:0];
    assign in_weight = s_tdata[wsmv_pkg::S_TDATA_W-1:wsmv_pkg::VALUE_W];
    assign s_tready  = (state_reg == wsmv_pkg::ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign full      = (cnt_reg == CNT_W'(MAX_SAMPLES));

    // distance from the mean
    assign mag = (rd_x_reg >= mean_reg) ? (rd_x_reg - mean_reg) : (mean_reg - rd_x_reg);

    // dividend for the rounded mean: 2S + W
    assign n1 = N1_W'({sum_reg, 1'b0}) + N1_W'(wt_reg);

    // shared multiplier operand select
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b0;
        unique case (state_reg)
            wsmv_pkg::ST_LMUL: begin
                mul_a  = wsmv_pkg::MUL_A_W'(x_reg);
                mul_b  = w_reg;
                mul_en = 1'b1;
            end
            wsmv_pkg::ST_PSQ: begin
                mul_a  = wsmv_pkg::MUL_A_W'(mag);
                mul_b  = mag;
                mul_en = 1'b1;
            end
            wsmv_pkg::ST_PWM: begin
                mul_a  = mul_reg[wsmv_pkg::MUL_A_W-1:0];
                mul_b  = rd_w_reg;
                mul_en = 1'b1;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    // divider operand select
    always_comb begin
        div_ctrl.start = 1'b0;
        div_ctrl.steps = wsmv_pkg::STEP_W'(wsmv_pkg::MEAN_STEPS);
        div_rem_init   = DEN_W'(n1 >> wsmv_pkg::MEAN_W);
        div_low        = {n1[wsmv_pkg::MEAN_W-1:0], {(wsmv_pkg::QUO_W-wsmv_pkg::MEAN_W){1'b0}}};
        div_den        = {wt_reg, 1'b0};
        if (state_reg == wsmv_pkg::ST_VSTART) begin
            div_ctrl.steps = wsmv_pkg::STEP_W'(wsmv_pkg::VAR_STEPS);
            div_rem_init   = DEN_W'(dsum_reg >> (wsmv_pkg::QUO_W - wsmv_pkg::FRAC_BITS));
            div_low        = {dsum_reg[wsmv_pkg::QUO_W-wsmv_pkg::FRAC_BITS-1:0],
                              {wsmv_pkg::FRAC_BITS{1'b0}}};
            div_den        = DEN_W'(wt_reg);
        end
        div_ctrl.start = (state_reg == wsmv_pkg::ST_MSTART && wt_reg != '0) ||
                         (state_reg == wsmv_pkg::ST_VSTART);
    end

    wsmv_div #(
        .DEN_W (DEN_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (div_ctrl),
        .rem_init (div_rem_init),
        .low_bits (div_low),
        .den      (div_den),
        .done     (div_done),
        .quotient (div_quo)
    );

    // sequencer: next state and datapath next values
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        sum_next     = sum_reg;
        wt_next      = wt_reg;
        drop_next    = drop_reg;
        dsum_next    = dsum_reg;
        x_next       = x_reg;
        w_next       = w_reg;
        last_next    = last_reg;
        mean_next    = mean_reg;
        var_next     = var_reg;
        zero_next    = zero_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        m_valid_next = m_valid_reg && !m_tready;
        o_mean_next  = o_mean_reg;
        o_var_next   = o_var_reg;
        o_zero_next  = o_zero_reg;
        o_drop_next  = o_drop_reg;
        o_used_next  = o_used_reg;
        unique case (state_reg)
            wsmv_pkg::ST_IDLE: begin
                if (s_accept) begin
                    x_next    = in_value;
                    w_next    = in_weight;
                    last_next = s_tlast;
                    if (full) begin
                        drop_next = 1'b1;
                        if (s_tlast) begin
                            state_next = wsmv_pkg::ST_MSTART;
                        end
                    end else begin
                        mem_we     = 1'b1;
                        state_next = wsmv_pkg::ST_LMUL;
                    end
                end
            end
            wsmv_pkg::ST_LMUL: begin
                state_next = wsmv_pkg::ST_LACC;
            end
            wsmv_pkg::ST_LACC: begin
                sum_next = sum_reg + SUM_W'(mul_reg[wsmv_pkg::MUL_A_W-1:0]);
                wt_next  = wt_reg + WT_W'(w_reg);
                cnt_next = cnt_reg + CNT_W'(1);
                state_next = last_reg ? wsmv_pkg::ST_MSTART : wsmv_pkg::ST_IDLE;
            end
            wsmv_pkg::ST_MSTART: begin
                if (wt_reg == '0) begin
                    mean_next  = '0;
                    var_next   = '0;
                    zero_next  = 1'b1;
                    state_next = wsmv_pkg::ST_DONE;
                end else begin
                    zero_next  = 1'b0;
                    state_next = wsmv_pkg::ST_MWAIT;
                end
            end
            wsmv_pkg::ST_MWAIT: begin
                if (div_done) begin
                    mean_next  = div_quo[wsmv_pkg::MEAN_W-1:0];
                    idx_next   = '0;
                    dsum_next  = '0;
                    state_next = wsmv_pkg::ST_PRD;
                end
            end
            wsmv_pkg::ST_PRD: begin
                mem_re     = 1'b1;
                state_next = wsmv_pkg::ST_PSQ;
            end
            wsmv_pkg::ST_PSQ: begin
                state_next = wsmv_pkg::ST_PWM;
            end
            wsmv_pkg::ST_PWM: begin
                state_next = wsmv_pkg::ST_PAC;
            end
            wsmv_pkg::ST_PAC: begin
                dsum_next = dsum_reg + DS_W'(mul_reg);
                idx_next  = idx_reg + CNT_W'(1);
                if (idx_reg + CNT_W'(1) == cnt_reg) begin
                    state_next = wsmv_pkg::ST_VSTART;
                end else begin
                    state_next = wsmv_pkg::ST_PRD;
                end
            end
            wsmv_pkg::ST_VSTART: begin
                state_next = wsmv_pkg::ST_VWAIT;
            end
            wsmv_pkg::ST_VWAIT: begin
                if (div_done) begin
                    var_next   = div_quo;
                    state_next = wsmv_pkg::ST_DONE;
                end
            end
            wsmv_pkg::ST_DONE: begin
                // load the result once the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    o_mean_next  = mean_reg;
                    o_var_next   = var_reg;
                    o_zero_next  = zero_reg;
                    o_drop_next  = drop_reg;
                    o_used_next  = wsmv_pkg::USED_W'(cnt_reg);
                    cnt_next     = '0;
                    sum_next     = '0;
                    wt_next      = '0;
                    drop_next    = 1'b0;
                    state_next   = wsmv_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = wsmv_pkg::ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wsmv_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // control and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            sum_reg     <= '0;
            wt_reg      <= '0;
            drop_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            sum_reg     <= sum_next;
            wt_reg      <= wt_next;
            drop_reg    <= drop_next;
            m_valid_reg <= m_valid_next;
        end
        idx_reg    <= idx_next;
        dsum_reg   <= dsum_next;
        x_reg      <= x_next;
        w_reg      <= w_next;
        last_reg   <= last_next;
        mean_reg   <= mean_next;
        var_reg    <= var_next;
        zero_reg   <= zero_next;
        o_mean_reg <= o_mean_next;
        o_var_reg  <= o_var_next;
        o_zero_reg <= o_zero_next;
        o_drop_reg <= o_drop_next;
        o_used_reg <= o_used_next;
        if (mul_en) begin
            mul_reg <= wsmv_pkg::MUL_P_W'(mul_a) * wsmv_pkg::MUL_P_W'(mul_b);
        end
    end

    // sample store write and registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            value_mem[cnt_reg[ADDR_W-1:0]]  <= in_value;
            weight_mem[cnt_reg[ADDR_W-1:0]] <= in_weight;
        end
        if (mem_re) begin
            rd_x_reg <= value_mem[idx_reg[ADDR_W-1:0]];
            rd_w_reg <= weight_mem[idx_reg[ADDR_W-1:0]];
        end
    end

    // result channel
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = wsmv_pkg::M_TDATA_W'({o_used_reg, o_var_reg, o_mean_reg});
    assign m_tuser  = {o_drop_reg, o_zero_reg};

endmodule

// ----- sv/wsmv_checker.sv -----
// ----------------------------------------------------------------------------
// wsmv_checker
// Port-level checks on the weighted mean/variance block, bound to the top.
// ----------------------------------------------------------------------------
module wsmv_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic                              s_tlast,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [wsmv_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic [wsmv_pkg::M_TUSER_W-1:0]    m_tuser
);

    localparam int STAT_W = wsmv_pkg::MEAN_W + wsmv_pkg::VAR_W;

    // no result directly after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // zero total weight reports zero mean and variance
    a_zero_weight: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[STAT_W-1:0] == '0)
        else $error("zero weight result carries nonzero statistics");

    // a sample taken with tlast never leaves the input open in the next cycle
    a_last_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input ready right after last sample");

endmodule

bind weighted_scalar_mean_variance wsmv_checker u_wsmv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- tb/sv/weighted_scalar_mean_variance_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// weighted_scalar_mean_variance_tb
// Self-checking regression for the weighted scalar mean/variance block. A
// directed table covers extremes, zero total weight and rounding. One set
// overruns the sample store. Random sets follow under several idle and stall
// patterns. Each result is compared field by field against the table's typed
// value or a behavioral predictor of the weighted mean and biased variance.
// ----------------------------------------------------------------------------
module weighted_scalar_mean_variance_tb;

    localparam int MAX_SAMPLES  = wsmv_pkg::MAX_SAMPLES_DEF;
    localparam int LIMIT_CYCLES = 600000;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 200;
    localparam int PHASE_ITEMS  = 78;

    // m_tuser bit positions
    localparam int ZERO_W_BIT   = 0;
    localparam int DROPPED_BIT  = 1;

    typedef struct packed {
        logic [wsmv_pkg::MEAN_W-1:0] mean;
        logic [wsmv_pkg::VAR_W-1:0]  variance;
        logic                        zero_w;
        logic                        dropped;
        logic [wsmv_pkg::USED_W-1:0] used;
    } stats_t;

    typedef struct packed {
        logic [wsmv_pkg::VALUE_W-1:0]  value;
        logic [wsmv_pkg::WEIGHT_W-1:0] weight;
        logic                          last;
        logic                          typed;
        stats_t                        result;
    } dir_row_t;

    typedef enum int {VAL_UNIFORM, VAL_CLUSTER, VAL_CORNER} value_mode_t;
    typedef enum int {WT_UNIFORM, WT_SMALL, WT_CORNER, WT_ZERO} weight_mode_t;

    logic                             aclk     = 1'b0;
    logic                             aresetn  = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [wsmv_pkg::S_TDATA_W-1:0]   s_tdata  = '0;
    logic                             s_tlast  = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [wsmv_pkg::M_TDATA_W-1:0]   m_tdata;
    logic [wsmv_pkg::M_TUSER_W-1:0]   m_tuser;

    // predictor state for the set being loaded
    logic [wsmv_pkg::VALUE_W-1:0]  set_values  [MAX_SAMPLES];
    logic [wsmv_pkg::WEIGHT_W-1:0] set_weights [MAX_SAMPLES];
    int unsigned                   set_count   = 0;
    longint unsigned               set_wsum    = 0;
    longint unsigned               set_wtotal  = 0;
    bit                            set_dropped = 1'b0;

    stats_t   pending_stats[$];
    dir_row_t dir_rows[$];

    int error_count     = 0;
    int cycle_count     = 0;
    int samples_sent    = 0;
    int results_checked = 0;
    int zero_sets       = 0;
    int dropped_sets    = 0;
    int src_idle_pct    = 0;
    int sink_stall_pct  = 0;
    int hold_requests   = 0;
    int holds_served    = 0;
    int hold_left       = 0;

    weighted_scalar_mean_variance u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // cycle limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, pending_stats.size());
            $display("weighted_scalar_mean_variance regression: fail");
            $finish;
        end
    end

    // result side ready, with random stalls and a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (hold_requests != holds_served) begin
                holds_served = hold_requests;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
            end
        end
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input longint unsigned got_v,
                               input longint unsigned want_v);
        if (got_v !== want_v)
            report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                      results_checked, name, got_v, want_v));
    endtask

    // weighted mean rounded half up, then biased weighted variance in q8
    function automatic bit predict_mean_variance(
        input logic [wsmv_pkg::VALUE_W-1:0] value,
        input logic [wsmv_pkg::WEIGHT_W-1:0] weight,
        input logic last,
        output stats_t res);
        longint unsigned x = 64'(value);
        longint unsigned w = 64'(weight);
        longint unsigned mean = 0;
        longint unsigned variance = 0;
        longint unsigned dsum = 0;
        longint unsigned mag;
        longint unsigned vi;
        longint unsigned q;
        longint unsigned r;
        res = '0;
        // store full: sample is dropped and stays out of the sums
        if (set_count < MAX_SAMPLES) begin
            set_values[set_count]  = value;
            set_weights[set_count] = weight;
            set_count++;
            set_wsum   += x * w;
            set_wtotal += w;
        end else begin
            set_dropped = 1'b1;
        end
        if (!last)
            return 1'b0;
        if (set_wtotal != 0) begin
            mean = (2 * set_wsum + set_wtotal) / (2 * set_wtotal);
            for (int i = 0; i < set_count; i++) begin
                vi   = 64'(set_values[i]);
                mag  = (vi >= mean) ? vi - mean : mean - vi;
                dsum += mag * mag * 64'(set_weights[i]);
            end
            q = dsum / set_wtotal;
            r = dsum % set_wtotal;
            variance = q * 256 + (r * 256) / set_wtotal;
        end
        res.mean     = mean[wsmv_pkg::MEAN_W-1:0];
        res.variance = variance[wsmv_pkg::VAR_W-1:0];
        res.zero_w   = (set_wtotal == 0);
        res.dropped  = set_dropped;
        res.used     = set_count[wsmv_pkg::USED_W-1:0];
        // next set starts clean
        set_count   = 0;
        set_wsum    = 0;
        set_wtotal  = 0;
        set_dropped = 1'b0;
        return 1'b1;
    endfunction

    // offer one sample transaction and record the expected result, if any
    task automatic send_sample(input logic [wsmv_pkg::VALUE_W-1:0] value,
                               input logic [wsmv_pkg::WEIGHT_W-1:0] weight,
                               input logic last, input logic typed,
                               input stats_t typed_res);
        stats_t res;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {weight, value};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        samples_sent++;
        if (predict_mean_variance(value, weight, last, res))
            pending_stats.push_back(typed ? typed_res : res);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_stats.size() != 0)
            @(posedge aclk);
    endtask

    function automatic dir_row_t mk_row(input int value, input int weight,
                                        input bit last, input bit typed,
                                        input int mean, input longint variance,
                                        input bit zero_w, input int used);
        dir_row_t row;
        row.value           = value[wsmv_pkg::VALUE_W-1:0];
        row.weight          = weight[wsmv_pkg::WEIGHT_W-1:0];
        row.last            = last;
        row.typed           = typed;
        row.result.mean     = mean[wsmv_pkg::MEAN_W-1:0];
        row.result.variance = variance[wsmv_pkg::VAR_W-1:0];
        row.result.zero_w   = zero_w;
        row.result.dropped  = 1'b0;
        row.result.used     = used[wsmv_pkg::USED_W-1:0];
        return row;
    endfunction

    function automatic logic [wsmv_pkg::VALUE_W-1:0] pick_value(
        input value_mode_t mode,
        input logic [wsmv_pkg::VALUE_W-1:0] base);
        case (mode)
            VAL_UNIFORM: return wsmv_pkg::VALUE_W'($urandom_range(0, 65535));
            VAL_CLUSTER: return wsmv_pkg::VALUE_W'(32'(base) + $urandom_range(0, 15) - 32'd8);
            default: begin
                case ($urandom_range(0, 3))
                    0:       return 16'h0000;
                    1:       return 16'hFFFF;
                    2:       return 16'h8000;
                    default: return 16'h0001;
                endcase
            end
        endcase
    endfunction

    function automatic logic [wsmv_pkg::WEIGHT_W-1:0] pick_weight(input weight_mode_t mode);
        case (mode)
            WT_UNIFORM: return wsmv_pkg::WEIGHT_W'($urandom_range(0, 65535));
            WT_SMALL:   return wsmv_pkg::WEIGHT_W'($urandom_range(0, 4));
            WT_ZERO:    return 16'h0000;
            default: begin
                case ($urandom_range(0, 3))
                    0:       return 16'h0000;
                    1:       return 16'hFFFF;
                    2:       return 16'h8000;
                    default: return 16'h0001;
                endcase
            end
        endcase
    endfunction

    // random sets, mostly short, each closed by a last sample
    task automatic run_random_phase(input int idle_pct, input int stall_pct,
                                    input int items);
        int                           sent = 0;
        int                           len;
        int                           pick;
        value_mode_t                  vmode;
        weight_mode_t                 wmode;
        logic [wsmv_pkg::VALUE_W-1:0] base;
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        while (sent < items) begin
            pick = $urandom_range(0, 99);
            len  = (pick < 60) ? $urandom_range(1, 4) :
                   (pick < 90) ? $urandom_range(5, 12) : $urandom_range(13, 40);
            vmode = value_mode_t'($urandom_range(0, 2));
            pick  = $urandom_range(0, 99);
            wmode = (pick < 5)  ? WT_ZERO :
                    (pick < 45) ? WT_UNIFORM :
                    (pick < 75) ? WT_SMALL : WT_CORNER;
            base  = wsmv_pkg::VALUE_W'($urandom_range(0, 65535));
            for (int k = 0; k < len; k++)
                send_sample(pick_value(vmode, base), pick_weight(wmode),
                            k == len - 1, 1'b0, '0);
            sent += len;
        end
        wait_drained();
    endtask

    // result checker
    always @(posedge aclk) begin
        stats_t got;
        stats_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.mean     = m_tdata[wsmv_pkg::MEAN_W-1:0];
            got.variance = m_tdata[wsmv_pkg::MEAN_W +: wsmv_pkg::VAR_W];
            got.used     = m_tdata[wsmv_pkg::MEAN_W + wsmv_pkg::VAR_W +: wsmv_pkg::USED_W];
            got.zero_w   = m_tuser[ZERO_W_BIT];
            got.dropped  = m_tuser[DROPPED_BIT];
            if (pending_stats.size() == 0) begin
                report_mismatch($sformatf("result with none expected: mean %0d used %0d",
                                          got.mean, got.used));
            end else begin
                want = pending_stats.pop_front();
                check_field("mean_value", 64'(got.mean), 64'(want.mean));
                check_field("variance_q8", 64'(got.variance), 64'(want.variance));
                check_field("zero_weight_error", 64'(got.zero_w), 64'(want.zero_w));
                check_field("capacity_overflow", 64'(got.dropped), 64'(want.dropped));
                check_field("samples_used", 64'(got.used), 64'(want.used));
                results_checked++;
                if (want.zero_w)
                    zero_sets++;
                if (want.dropped)
                    dropped_sets++;
            end
        end
    end

    // stimulus
    initial begin
        // single-sample sets: zero weight, extremes
        dir_rows.push_back(mk_row(0,      0,     1, 1, 0,     0,   1, 1));
        dir_rows.push_back(mk_row(65535,  65535, 1, 1, 65535, 0,   0, 1));
        dir_rows.push_back(mk_row(0,      65535, 1, 1, 0,     0,   0, 1));
        dir_rows.push_back(mk_row(65535,  0,     1, 1, 0,     0,   1, 1));
        // zero total weight over two samples
        dir_rows.push_back(mk_row(100,    0,     0, 0, 0,     0,   0, 0));
        dir_rows.push_back(mk_row(200,    0,     1, 1, 0,     0,   1, 2));
        // mean 1.5 rounds up, lower sample sits below the mean
        dir_rows.push_back(mk_row(1,      1,     0, 0, 0,     0,   0, 0));
        dir_rows.push_back(mk_row(2,      1,     1, 1, 2,     128, 0, 2));
        // zero-weight sample has no effect on mean or variance
        dir_rows.push_back(mk_row(500,    0,     0, 0, 0,     0,   0, 0));
        dir_rows.push_back(mk_row(7,      3,     1, 1, 7,     0,   0, 2));
        // widest spread, midpoint rounding
        dir_rows.push_back(mk_row(0,      65535, 0, 0, 0,     0,   0, 0));
        dir_rows.push_back(mk_row(65535,  65535, 1, 0, 0,     0,   0, 0));
        // alternating bit patterns and near-extreme values in value and weight
        dir_rows.push_back(mk_row('hAAAA, 'h5555, 0, 0, 0,    0,   0, 0));
        dir_rows.push_back(mk_row('h5555, 'hAAAA, 0, 0, 0,    0,   0, 0));
        dir_rows.push_back(mk_row('h0001, 'hFFFF, 0, 0, 0,    0,   0, 0));
        dir_rows.push_back(mk_row('hFFFE, 'h0001, 1, 0, 0,    0,   0, 0));
        // uneven weights
        dir_rows.push_back(mk_row(10,     1,     0, 0, 0,     0,   0, 0));
        dir_rows.push_back(mk_row(20,     3,     1, 0, 0,     0,   0, 0));

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            send_sample(dir_rows[i].value, dir_rows[i].weight, dir_rows[i].last,
                        dir_rows[i].typed, dir_rows[i].result);
        wait_drained();

        // overrun the store: two samples dropped, the last of them closes the set
        for (int k = 0; k < MAX_SAMPLES + 2; k++)
            send_sample(wsmv_pkg::VALUE_W'($urandom_range(0, 65535)),
                        wsmv_pkg::WEIGHT_W'($urandom_range(0, 65535)),
                        k == MAX_SAMPLES + 1, 1'b0, '0);
        wait_drained();

        // long result hold-off while samples keep coming, then idle patterns
        hold_requests++;
        run_random_phase(0, 0, PHASE_ITEMS);
        run_random_phase(67, 0, PHASE_ITEMS);
        run_random_phase(0, 67, PHASE_ITEMS);
        run_random_phase(24, 24, PHASE_ITEMS);

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_stats.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_stats.size()));

        $display("sent %0d samples, checked %0d result sets (%0d with zero weight, %0d overrun)",
                 samples_sent, results_checked, zero_sets, dropped_sets);
        $display("idle patterns: none, source 67%%, sink 67%%, both 24%%, one %0d-cycle hold-off",
                 HOLD_CYCLES);
        if (error_count == 0) begin
            $display("weighted_scalar_mean_variance regression: pass");
        end else begin
            $display("%0d mismatches", error_count);
            $display("weighted_scalar_mean_variance regression: fail");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/wsmv_pkg.sv
sv/wsmv_div.sv
sv/weighted_scalar_mean_variance.sv
sv/wsmv_checker.sv
tb/sv/weighted_scalar_mean_variance_tb.sv
